[hdl/ovpg_pkg.sv]
package ovpg_pkg;

    // Configuration port
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VMAX_LIN = 2'd0,
        REG_VMAX_ANG = 2'd1,
        REG_AMAX_LIN = 2'd2,
        REG_AMAX_ANG = 2'd3
    } cfg_reg_t;

    // Register reset values, raw Q7.24
    localparam logic [CFG_W-1:0] VMAX_LIN_RST = 31'd8388608;
    localparam logic [CFG_W-1:0] VMAX_ANG_RST = 31'd16777216;
    localparam logic [CFG_W-1:0] AMAX_LIN_RST = 31'd16777216;
    localparam logic [CFG_W-1:0] AMAX_ANG_RST = 31'd33554432;

    // Item modes
    localparam logic MODE_STEP   = 1'b0;
    localparam logic MODE_PRESET = 1'b1;

    // First angular axis
    localparam logic [2:0] AXIS_FIRST_ANG = 3'd3;

    // Divisions by constants as reciprocal multiplications: RECIP_K is 2^38/1000
    // rounded up, exact for 32-bit dividends at shift 38 (/1000) and 35 (/125).
    // Acceleration step is amax/1000, position step uses /125 after >>4
    localparam logic [28:0] RECIP_K    = 29'd274877907;
    localparam int          SH_ACC     = 38;
    localparam int          SH_POS     = 35;
    localparam logic [31:0] ACC_ROUND  = 32'd500;
    // Bias keeps the position dividend positive: 125 * 2^23
    localparam logic [31:0] POS_BIAS   = 32'd1048576000;
    localparam logic [33:0] POS_BIAS_Q = 34'd8388608;

    // Last iteration indices of the multiplier, square root and clamp passes
    localparam logic [4:0] ITER_LAST  = 5'd31;
    localparam logic [4:0] CLAMP_LAST = 5'd2;

    // pi scaled by 2^60
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Home pose of one axis, rounded to nearest at the given fraction width
    function automatic logic signed [31:0] home_pos(input int unsigned axis,
                                                    input int unsigned frac);
        logic [63:0] pi_q;
        logic [63:0] hpi_q;
        logic [63:0] val;
        pi_q  = (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
        hpi_q = (PI_Q60 + (64'd1 << (60 - frac))) >> (61 - frac);
        case (axis)
            0:       val = ((64'd3 << frac) + 64'd5) / 64'd10;
            1:       val = ((64'd35 << frac) + 64'd50) / 64'd100;
            3:       val = 64'd0 - hpi_q;
            5:       val = pi_q;
            default: val = 64'd0;
        endcase
        return val[31:0];
    endfunction

endpackage

[hdl/online_velocity_profile_generator_unit.sv]
// Online velocity profile generator: one axis update per in-range input item.
// Input channel (s_*): mode, arm, axis and target. Step mode moves the axis
// toward target with the speed limit, the braking limit sqrt(2*amax*|err|)
// and the per-tick acceleration limit, then integrates position with the
// trapezoid rule. Preset mode loads the position and zeroes the velocity.
// Items naming an arm or axis out of range are taken and dropped.
// Result channel (m_*): arm, axis, new position and velocity, held in an
// output register until taken.
// A step item passes in turn through read, setup, the bit-serial multiplier,
// the square root, the clamp passes, velocity saturation and the position
// steps; a preset item goes straight to the finish step. No new item is taken
// until the current one reaches the output register. One sequencer runs the
// multiplier and square root in sequence; divisions by constants use reciprocals.
// A new item is taken while the previous result still waits; a stalled
// receiver only holds the finished update, which waits until the output
// register frees up. Reset restores the home pose and zero velocity on every
// axis (per-entry valid bits, no clearing pass) and the register reset values.
// Registers are written through cfg_wr_en/cfg_addr/cfg_wdata by the user only
// while the block is idle; the block itself does not enforce this.
module online_velocity_profile_generator_unit #(
    parameter int NUM_ARMS  = 2,
    parameter int NUM_AXES  = 6,
    parameter int FRAC_BITS = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ovpg_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ovpg_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic                             s_arm,
    input  logic [2:0]                       s_axis,
    input  logic signed [31:0]               s_target,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_arm_out,
    output logic [2:0]                       m_axis_out,
    output logic signed [31:0]               m_position,
    output logic signed [31:0]               m_velocity
);

    import ovpg_pkg::*;

    localparam int DEPTH = NUM_ARMS * NUM_AXES;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] DEAD_BAND =
        32'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic signed [31:0] HOME_POS [8] = '{
        home_pos(0, FRAC_BITS), home_pos(1, FRAC_BITS),
        home_pos(2, FRAC_BITS), home_pos(3, FRAC_BITS),
        home_pos(4, FRAC_BITS), home_pos(5, FRAC_BITS),
        home_pos(6, FRAC_BITS), home_pos(7, FRAC_BITS)
    };
    localparam logic signed [43:0] V_MAX44 = 44'sd2147483647;
    localparam logic signed [43:0] V_MIN44 = -44'sd2147483648;
    localparam logic signed [33:0] P_MAX34 = 34'sd2147483647;
    localparam logic signed [33:0] P_MIN34 = -34'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SETUP,
        ST_MUL,
        ST_SQRT,
        ST_CLAMP,
        ST_VSAT,
        ST_PSET,
        ST_PDIV,
        ST_POSN,
        ST_FINISH
    } state_t;

    // Control registers
    state_t              state_reg, state_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [CFG_W-1:0]    vmax_lin_reg, vmax_lin_next;
    logic [CFG_W-1:0]    vmax_ang_reg, vmax_ang_next;
    logic [CFG_W-1:0]    amax_lin_reg, amax_lin_next;
    logic [CFG_W-1:0]    amax_ang_reg, amax_ang_next;
    logic [DEPTH-1:0]    vld_reg, vld_next;
    logic                m_valid_reg, m_valid_next;

    // Item and datapath registers
    logic                mode_reg, mode_next;
    logic                arm_reg, arm_next;
    logic [2:0]          axis_reg, axis_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic signed [31:0]  tgt_reg, tgt_next;
    logic                hit_reg, hit_next;
    logic signed [31:0]  lp_reg, lp_next;
    logic signed [31:0]  lv_reg, lv_next;
    logic                neg_reg, neg_next;
    logic signed [43:0]  v_reg, v_next;
    logic [63:0]         mcand_reg, mcand_next;
    logic [31:0]         mplier_reg, mplier_next;
    logic [63:0]         acc_reg, acc_next;
    logic [31:0]         dvd_reg, dvd_next;
    logic [21:0]         dv_reg, dv_next;
    logic [63:0]         rad_reg, rad_next;
    logic [33:0]         srem_reg, srem_next;
    logic [31:0]         root_reg, root_next;
    logic signed [31:0]  vel_reg, vel_next;
    logic signed [31:0]  pos_reg, pos_next;
    logic                m_arm_reg, m_arm_next;
    logic [2:0]          m_axis_reg, m_axis_next;
    logic signed [31:0]  m_pos_reg, m_pos_next;
    logic signed [31:0]  m_vel_reg, m_vel_next;

    // Axis state memory
    logic signed [31:0]  pos_mem [DEPTH];
    logic signed [31:0]  vel_mem [DEPTH];
    logic signed [31:0]  pos_rd_reg;
    logic signed [31:0]  vel_rd_reg;
    logic                mem_we;

    // Combinational helpers
    logic                in_accept;
    logic                in_range;
    logic                out_free;
    logic                lin;
    logic [CFG_W-1:0]    vmax_sel;
    logic [CFG_W-1:0]    amax_sel;
    logic signed [31:0]  lp_cur;
    logic signed [32:0]  err;
    logic signed [43:0]  err44;
    logic [31:0]         mag;
    logic [60:0]         recip_prod;
    logic [63:0]         mul_acc;
    logic [35:0]         sq_t;
    logic [35:0]         sq_trial;
    logic                sq_ge;
    logic [33:0]         sq_rem;
    logic [31:0]         sq_root;
    logic signed [43:0]  vmax44;
    logic signed [43:0]  brake44;
    logic signed [43:0]  lim;
    logic signed [43:0]  v_clamp;
    logic signed [33:0]  pinc;
    logic signed [33:0]  pinc_sh;
    logic signed [33:0]  pnew;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_accept  = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_arm_out  = m_arm_reg;
    assign m_axis_out = m_axis_reg;
    assign m_position = m_pos_reg;
    assign m_velocity = m_vel_reg;

    assign in_range = (int'(s_arm) < NUM_ARMS) && (int'(s_axis) < NUM_AXES);

    // Per-axis limits
    assign lin      = (axis_reg < AXIS_FIRST_ANG);
    assign vmax_sel = lin ? vmax_lin_reg : vmax_ang_reg;
    assign amax_sel = lin ? amax_lin_reg : amax_ang_reg;

    // Position error against stored or home position
    assign lp_cur = hit_reg ? pos_rd_reg : HOME_POS[axis_reg];
    assign err    = 33'(tgt_reg) - 33'(lp_cur);
    assign err44  = 44'(err);
    assign mag    = err[32] ? 32'(-err) : err[31:0];

    // Reciprocal multiply for the divisions by 1000 and 125
    assign recip_prod = 61'(dvd_reg) * 61'(RECIP_K);

    // Shift-add multiplier step
    assign mul_acc = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

    // Square root step, one result bit
    assign sq_t     = {srem_reg, rad_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);
    assign sq_rem   = sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
    assign sq_root  = {root_reg[30:0], sq_ge};

    // Clamp limit for the current pass, on the side of the motion
    assign vmax44  = 44'(vmax_sel);
    assign brake44 = 44'(root_reg);
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    lim = neg_reg ? -vmax44 : vmax44;
            2'd1:    lim = neg_reg ? -brake44 : brake44;
            default: lim = neg_reg ? (44'(lv_reg) - 44'(dv_reg))
                                   : (44'(lv_reg) + 44'(dv_reg));
        endcase
    end
    assign v_clamp = (neg_reg ? (v_reg < lim) : (v_reg > lim)) ? lim : v_reg;

    // Trapezoid increment and new position
    assign pinc    = 34'(vel_reg) + 34'(lv_reg) + 34'sd1000;
    assign pinc_sh = pinc >>> 4;
    assign pnew    = 34'(lp_reg) + $signed({2'b00, dvd_reg}) - $signed(POS_BIAS_Q);

    // Next-state logic
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        vmax_lin_next = vmax_lin_reg;
        vmax_ang_next = vmax_ang_reg;
        amax_lin_next = amax_lin_reg;
        amax_ang_next = amax_ang_reg;
        vld_next      = vld_reg;
        m_valid_next  = m_valid_reg;
        mode_next     = mode_reg;
        arm_next      = arm_reg;
        axis_next     = axis_reg;
        idx_next      = idx_reg;
        tgt_next      = tgt_reg;
        hit_next      = hit_reg;
        lp_next       = lp_reg;
        lv_next       = lv_reg;
        neg_next      = neg_reg;
        v_next        = v_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        acc_next      = acc_reg;
        dvd_next      = dvd_reg;
        dv_next       = dv_reg;
        rad_next      = rad_reg;
        srem_next     = srem_reg;
        root_next     = root_reg;
        vel_next      = vel_reg;
        pos_next      = pos_reg;
        m_arm_next    = m_arm_reg;
        m_axis_next   = m_axis_reg;
        m_pos_next    = m_pos_reg;
        m_vel_next    = m_vel_reg;
        mem_we        = 1'b0;

        // Register writes
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_VMAX_LIN: vmax_lin_next = cfg_wdata;
                REG_VMAX_ANG: vmax_ang_next = cfg_wdata;
                REG_AMAX_LIN: amax_lin_next = cfg_wdata;
                REG_AMAX_ANG: amax_ang_next = cfg_wdata;
                default: ;
            endcase
        end

        // Drop the output once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    mode_next = s_mode;
                    arm_next  = s_arm;
                    axis_next = s_axis;
                    tgt_next  = s_target;
                    idx_next  = IDX_W'(int'(s_arm) * NUM_AXES + int'(s_axis));
                    if (!in_range) begin
                        state_next = ST_IDLE;
                    end else if (s_mode == MODE_PRESET) begin
                        pos_next   = s_target;
                        vel_next   = '0;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                hit_next   = vld_reg[idx_reg];
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                lp_next     = lp_cur;
                lv_next     = hit_reg ? vel_rd_reg : '0;
                neg_next    = err[32];
                v_next      = (err44 <<< 10) - (err44 <<< 4) - (err44 <<< 3);
                mcand_next  = (mag < DEAD_BAND) ? '0 : {32'd0, mag};
                mplier_next = 32'(amax_sel);
                acc_next    = '0;
                dvd_next    = 32'(amax_sel) + ACC_ROUND;
                cnt_next    = '0;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                // Advance the product; take the acceleration step on the last pass
                acc_next    = mul_acc;
                mcand_next  = {mcand_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
                if (cnt_reg == ITER_LAST) begin
                    dv_next    = recip_prod[SH_ACC +: 22];
                    rad_next   = {mul_acc[62:0], 1'b0};
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SQRT: begin
                srem_next = sq_rem;
                root_next = sq_root;
                rad_next  = {rad_reg[61:0], 2'b00};
                if (cnt_reg == ITER_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_CLAMP;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_CLAMP: begin
                // Speed, braking and acceleration limits in turn
                v_next = v_clamp;
                if (cnt_reg == CLAMP_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_VSAT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_VSAT: begin
                if (v_reg > V_MAX44) begin
                    vel_next = V_MAX44[31:0];
                end else if (v_reg < V_MIN44) begin
                    vel_next = V_MIN44[31:0];
                end else begin
                    vel_next = v_reg[31:0];
                end
                state_next = ST_PSET;
            end
            ST_PSET: begin
                dvd_next   = 32'(pinc_sh) + POS_BIAS;
                state_next = ST_PDIV;
            end
            ST_PDIV: begin
                dvd_next   = 32'(recip_prod[SH_POS +: 26]);
                state_next = ST_POSN;
            end
            ST_POSN: begin
                if (pnew > P_MAX34) begin
                    pos_next = P_MAX34[31:0];
                end else if (pnew < P_MIN34) begin
                    pos_next = P_MIN34[31:0];
                end else begin
                    pos_next = pnew[31:0];
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold until the output register is free, then store and present
                if (out_free) begin
                    mem_we            = 1'b1;
                    vld_next[idx_reg] = 1'b1;
                    m_valid_next      = 1'b1;
                    m_arm_next        = arm_reg;
                    m_axis_next       = axis_reg;
                    m_pos_next        = pos_reg;
                    m_vel_next        = vel_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs
    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        arm_reg    <= arm_next;
        axis_reg   <= axis_next;
        idx_reg    <= idx_next;
        tgt_reg    <= tgt_next;
        hit_reg    <= hit_next;
        lp_reg     <= lp_next;
        lv_reg     <= lv_next;
        neg_reg    <= neg_next;
        v_reg      <= v_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        dvd_reg    <= dvd_next;
        dv_reg     <= dv_next;
        rad_reg    <= rad_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        vel_reg    <= vel_next;
        pos_reg    <= pos_next;
        m_arm_reg  <= m_arm_next;
        m_axis_reg <= m_axis_next;
        m_pos_reg  <= m_pos_next;
        m_vel_reg  <= m_vel_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            vmax_lin_reg <= VMAX_LIN_RST;
            vmax_ang_reg <= VMAX_ANG_RST;
            amax_lin_reg <= AMAX_LIN_RST;
            amax_ang_reg <= AMAX_ANG_RST;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            vmax_lin_reg <= vmax_lin_next;
            vmax_ang_reg <= vmax_ang_next;
            amax_lin_reg <= amax_lin_next;
            amax_ang_reg <= amax_ang_next;
            vld_reg      <= vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Axis state memory: one write and one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pos_mem[idx_reg] <= pos_reg;
            vel_mem[idx_reg] <= vel_reg;
        end
        if (state_reg == ST_READ) begin
            pos_rd_reg <= pos_mem[idx_reg];
            vel_rd_reg <= vel_mem[idx_reg];
        end
    end

    // A result appears only out of the finish step
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish step");

    // Preset leaves the axis at rest
    a_preset_at_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && mode_reg == MODE_PRESET) |-> (vel_reg == '0))
        else $error("preset item with nonzero velocity");

    // Forward motion never exceeds the speed limit after clamping
    a_fwd_speed_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VSAT && !neg_reg) |-> (v_reg <= vmax44))
        else $error("forward velocity above speed limit");

endmodule

[verif/ovpg_axis_checker.sv]
module ovpg_axis_checker #(
    parameter int NUM_ARMS  = 2,
    parameter int NUM_AXES  = 6,
    parameter int FRAC_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ovpg_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [ovpg_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_mode,
    input  logic                           s_arm,
    input  logic [2:0]                     s_axis,
    input  logic signed [31:0]             s_target,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_arm_out,
    input  logic [2:0]                     m_axis_out,
    input  logic signed [31:0]             m_position,
    input  logic signed [31:0]             m_velocity,
    output int                             err_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ovpg_pkg::*;

    localparam longint unsigned DEAD_BAND =
        ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef struct {
        logic               arm;
        logic [2:0]         axis;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } axis_update_t;

    // Limit registers and per-axis motion state as the block should hold them
    logic [CFG_W-1:0]   vmax_lin, vmax_ang, amax_lin, amax_ang;
    logic signed [31:0] pos_q [NUM_ARMS][NUM_AXES];
    logic signed [31:0] vel_q [NUM_ARMS][NUM_AXES];
    axis_update_t       pending_updates [$];

    initial begin
        err_count   = 0;
        outstanding = 0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic longint clip32(input longint x);
        if (x > S32_HI) return S32_HI;
        if (x < S32_LO) return S32_LO;
        return x;
    endfunction

    // Round to nearest, halves up, while dropping s fraction bits
    function automatic logic [63:0] round_shift(input logic [63:0] x, input int s);
        return (x + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic signed [31:0] home_of(input int ax);
        logic [63:0] hv;
        case (ax)
            0:       hv = ((64'd3 << FRAC_BITS) + 64'd5) / 64'd10;
            1:       hv = ((64'd35 << FRAC_BITS) + 64'd50) / 64'd100;
            3:       hv = -round_shift(PI_Q60, 61 - FRAC_BITS);
            5:       hv = round_shift(PI_Q60, 60 - FRAC_BITS);
            default: hv = '0;
        endcase
        return hv[31:0];
    endfunction

    // Bitwise integer square root, floor
    function automatic longint unsigned isqrt_floor(input longint unsigned x);
        longint unsigned rem, root, b;
        rem  = x;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // One axis update: returns 0 when the item is dropped
    function automatic bit advance_axis(input logic mode, input logic arm,
                                        input logic [2:0] ax,
                                        input logic signed [31:0] target,
                                        output axis_update_t upd);
        longint          lp, lv, e, v, vmax, brake, dv, pos, vel, sum, q;
        longint unsigned amax, mag;
        bit              lin;
        if (int'(arm) >= NUM_ARMS || int'(ax) >= NUM_AXES) return 1'b0;
        if (mode == MODE_PRESET) begin
            pos = target;
            vel = 0;
        end else begin
            lp    = pos_q[arm][ax];
            lv    = vel_q[arm][ax];
            lin   = ax < AXIS_FIRST_ANG;
            vmax  = lin ? vmax_lin : vmax_ang;
            amax  = lin ? amax_lin : amax_ang;
            e     = longint'(target) - lp;
            mag   = (e < 0) ? -e : e;
            dv    = (amax + 64'd500) / 64'd1000;
            v     = e * 1000;
            brake = 0;
            // braking limit, zero inside the dead band; the product fits in 64 bits
            if (mag >= DEAD_BAND) brake = isqrt_floor(64'd2 * amax * mag);
            if (v >= 0) begin
                if (v > vmax) v = vmax;
                if (v > brake) v = brake;
                if (v > lv + dv) v = lv + dv;
            end else begin
                if (v < -vmax) v = -vmax;
                if (v < -brake) v = -brake;
                if (v < lv - dv) v = lv - dv;
            end
            vel = clip32(v);
            // trapezoid over half a tick, floor division
            sum = vel + lv + 1000;
            q   = sum / 2000;
            if (sum % 2000 != 0 && sum < 0) q = q - 1;
            pos = clip32(lp + q);
        end
        pos_q[arm][ax] = pos[31:0];
        vel_q[arm][ax] = vel[31:0];
        upd.arm  = arm;
        upd.axis = ax;
        upd.pos  = pos[31:0];
        upd.vel  = vel[31:0];
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        axis_update_t want, upd;
        if (!aresetn) begin
            // restore limits and home pose
            vmax_lin = VMAX_LIN_RST;
            vmax_ang = VMAX_ANG_RST;
            amax_lin = AMAX_LIN_RST;
            amax_ang = AMAX_ANG_RST;
            for (int a = 0; a < NUM_ARMS; a++) begin
                for (int x = 0; x < NUM_AXES; x++) begin
                    pos_q[a][x] = home_of(x);
                    vel_q[a][x] = '0;
                end
            end
            pending_updates.delete();
        end else begin
            // compare a taken result with the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_updates.size() == 0) begin
                    flag_error($sformatf("result arm %0d axis %0d with nothing expected",
                                         m_arm_out, m_axis_out));
                end else begin
                    want = pending_updates.pop_front();
                    if (m_arm_out !== want.arm)
                        flag_error($sformatf("arm_out %0d, expected %0d",
                                             m_arm_out, want.arm));
                    if (m_axis_out !== want.axis)
                        flag_error($sformatf("axis_out %0d, expected %0d",
                                             m_axis_out, want.axis));
                    if (m_position !== want.pos)
                        flag_error($sformatf("arm %0d axis %0d position %0d, expected %0d",
                                             want.arm, want.axis, m_position, want.pos));
                    if (m_velocity !== want.vel)
                        flag_error($sformatf("arm %0d axis %0d velocity %0d, expected %0d",
                                             want.arm, want.axis, m_velocity, want.vel));
                end
            end
            // predict the result of a taken item
            if (s_valid && s_ready) begin
                if (advance_axis(s_mode, s_arm, s_axis, s_target, upd))
                    pending_updates.push_back(upd);
            end
            // track register writes
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_VMAX_LIN: vmax_lin = cfg_wdata;
                    REG_VMAX_ANG: vmax_ang = cfg_wdata;
                    REG_AMAX_LIN: amax_lin = cfg_wdata;
                    REG_AMAX_ANG: amax_ang = cfg_wdata;
                    default: ;
                endcase
            end
        end
        outstanding = pending_updates.size();
    end

endmodule

[verif/tb_online_velocity_profile_generator_unit.sv]
module tb_online_velocity_profile_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ovpg_pkg::*;

    localparam int NUM_ARMS      = 2;
    localparam int NUM_AXES      = 6;
    localparam int FRAC_BITS     = 24;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 115;
    localparam logic [CFG_W-1:0]   LIM_MAX = '1;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh80000000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_mode;
    logic                 s_arm;
    logic [2:0]           s_axis;
    logic signed [31:0]   s_target;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_arm_out;
    logic [2:0]           m_axis_out;
    logic signed [31:0]   m_position;
    logic signed [31:0]   m_velocity;
    int                   err_count;
    int                   outstanding;

    int                   tx_idle_pct;
    int                   rx_idle_pct;
    bit                   hold_off_req;
    int                   n_steps, n_presets, n_dropped;
    logic signed [31:0]   goal [NUM_ARMS][NUM_AXES];

    online_velocity_profile_generator_unit #(
        .NUM_ARMS(NUM_ARMS), .NUM_AXES(NUM_AXES), .FRAC_BITS(FRAC_BITS)
    ) dut (.*);

    ovpg_axis_checker #(
        .NUM_ARMS(NUM_ARMS), .NUM_AXES(NUM_AXES), .FRAC_BITS(FRAC_BITS)
    ) u_checker (.*);

    always #10 aclk = ~aclk;

    // Give up after a generous fixed time
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Result side: random back-pressure, with one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item and hold it until taken; valid stays up across items unless an idle gap is drawn
    task automatic send_item(input logic mode, input logic arm, input logic [2:0] ax,
                             input logic signed [31:0] target);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_arm    <= arm;
        s_axis   <= ax;
        s_target <= target;
        do @(posedge aclk); while (!s_ready);
        if (int'(ax) >= NUM_AXES) n_dropped++;
        else if (mode == MODE_PRESET) n_presets++;
        else n_steps++;
    endtask

    // Drop valid, wait for every result, then let the block go quiet
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_limits(input logic [CFG_W-1:0] vl, input logic [CFG_W-1:0] va,
                               input logic [CFG_W-1:0] al, input logic [CFG_W-1:0] aa);
        write_reg(REG_VMAX_LIN, vl);
        write_reg(REG_VMAX_ANG, va);
        write_reg(REG_AMAX_LIN, al);
        write_reg(REG_AMAX_ANG, aa);
        cfg_wr_en <= 1'b0;
    endtask

    // Move a goal by a tiny, small, medium or arbitrary amount
    function automatic logic signed [31:0] shift_goal(input logic signed [31:0] g);
        longint d, t;
        case ($urandom_range(3))
            0:       d = longint'($urandom_range(40)) - 20;
            1:       d = longint'($urandom_range(1 << 15)) - (1 << 14);
            2:       d = longint'($urandom_range(1 << 23)) - (1 << 22);
            default: return $urandom;
        endcase
        t = longint'(g) + d;
        if (t > longint'(POS_MAX)) t = POS_MAX;
        if (t < longint'(POS_MIN)) t = POS_MIN;
        return t[31:0];
    endfunction

    // Bursts of steps on one axis toward a held goal, with presets,
    // stray targets and dropped axes mixed in
    task automatic run_phase(input int n);
        int                 done_cnt, burst, r;
        logic               arm;
        logic [2:0]         ax;
        logic signed [31:0] tgt;
        done_cnt = 0;
        while (done_cnt < n) begin
            arm = 1'($urandom_range(1));
            if ($urandom_range(99) < 4) begin
                send_item(1'($urandom_range(1)), arm, 3'($urandom_range(7, NUM_AXES)),
                          $urandom);
            end else begin
                ax = 3'($urandom_range(NUM_AXES - 1));
                if ($urandom_range(99) < 40) goal[arm][ax] = shift_goal(goal[arm][ax]);
                burst = $urandom_range(16, 1);
                repeat (burst) begin
                    r = $urandom_range(99);
                    if (r < 5) begin
                        tgt = $urandom_range(1) ? goal[arm][ax] : $urandom;
                        goal[arm][ax] = tgt;
                        send_item(MODE_PRESET, arm, ax, tgt);
                    end else if (r < 10) begin
                        send_item(MODE_STEP, arm, ax, $urandom);
                    end else begin
                        send_item(MODE_STEP, arm, ax, goal[arm][ax]);
                    end
                end
                done_cnt += burst;
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = REG_VMAX_LIN;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_mode       = MODE_STEP;
        s_arm        = 1'b0;
        s_axis       = '0;
        s_target     = '0;
        tx_idle_pct  = 19;
        rx_idle_pct  = 82;
        hold_off_req = 1'b0;
        n_steps      = 0;
        n_presets    = 0;
        n_dropped    = 0;
        for (int a = 0; a < NUM_ARMS; a++)
            for (int x = 0; x < NUM_AXES; x++)
                goal[a][x] = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limits: hold at home, full-range targets, dead band edges
        send_item(MODE_STEP, 1'b0, 3'd0, 32'sd5033165);
        send_item(MODE_STEP, 1'b0, 3'd0, POS_MAX);
        send_item(MODE_STEP, 1'b0, 3'd0, POS_MAX);
        send_item(MODE_STEP, 1'b1, 3'd1, POS_MIN);
        send_item(MODE_PRESET, 1'b1, 3'd2, 32'sd0);
        send_item(MODE_STEP, 1'b1, 3'd2, 32'sd16);
        send_item(MODE_STEP, 1'b1, 3'd2, -32'sd16);
        send_item(MODE_STEP, 1'b1, 3'd2, 32'sd17);
        send_item(MODE_STEP, 1'b1, 3'd2, -32'sd17);
        send_item(MODE_PRESET, 1'b0, 3'd3, POS_MIN);
        send_item(MODE_STEP, 1'b0, 3'd3, POS_MAX);
        send_item(MODE_PRESET, 1'b1, 3'd5, POS_MAX);
        send_item(MODE_STEP, 1'b1, 3'd5, POS_MIN);
        send_item(MODE_STEP, 1'b0, 3'd4, -32'sd1);
        // axes past the last one are dropped
        send_item(MODE_STEP, 1'b1, 3'd6, POS_MAX);
        send_item(MODE_PRESET, 1'b0, 3'd7, POS_MIN);
        drain();

        // Widest limits: overshoot into position saturation both ways
        load_limits(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX);
        send_item(MODE_PRESET, 1'b0, 3'd0, POS_MAX - 32'sd3000);
        send_item(MODE_STEP, 1'b0, 3'd0, POS_MAX);
        send_item(MODE_STEP, 1'b0, 3'd0, POS_MAX);
        send_item(MODE_PRESET, 1'b1, 3'd4, POS_MIN + 32'sd3000);
        send_item(MODE_STEP, 1'b1, 3'd4, POS_MIN);
        send_item(MODE_STEP, 1'b1, 3'd4, POS_MIN);
        send_item(MODE_STEP, 1'b0, 3'd1, POS_MIN);
        drain();

        // Random phases, each under its own limits; the idle pattern changes every two phases
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_limits(VMAX_LIN_RST, VMAX_ANG_RST, AMAX_LIN_RST, AMAX_ANG_RST);
                1: load_limits(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
                2: load_limits('0, '0, '0, '0);
                3: load_limits(31'($urandom_range(1 << 25)), 31'($urandom_range(1 << 25)),
                               31'($urandom_range(1 << 27)), 31'($urandom_range(1 << 27)));
                4: load_limits(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX);
                default: load_limits('0, LIM_MAX, 31'($urandom_range(1 << 26)), LIM_MAX);
            endcase
            if (ph < 2) begin
                tx_idle_pct = 19;
                rx_idle_pct = 82;
            end else if (ph < 4) begin
                tx_idle_pct = 82;
                rx_idle_pct = 19;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // stall the result side while items keep coming
            if (ph == 4) hold_off_req = 1'b1;
            run_phase(PHASE_ITEMS);
            drain();
        end

        $display("Run covered %0d steps and %0d presets under 8 limit settings; %0d items dropped",
                 n_steps, n_presets, n_dropped);
        $display("Back-pressure up to 82%% on either side plus one %0d-cycle result stall",
                 HOLD_CYCLES);
        if (err_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
